@@ hw/rtl/cdr_pkg.sv @@
// ----------------------------------------------------------------------------
// CDR field reader package
// Function codes, status codes, header constants and the command and status
// types that join the controller and the datapath.
// ----------------------------------------------------------------------------
package cdr_pkg;

  localparam logic [2:0] FUNC_WRITE  = 3'd0;
  localparam logic [2:0] FUNC_OPEN   = 3'd1;
  localparam logic [2:0] FUNC_SCALAR = 3'd2;
  localparam logic [2:0] FUNC_SPAN   = 3'd3;
  localparam logic [2:0] FUNC_STRING = 3'd4;

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_SHORT       = 2'd1;
  localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;
  localparam logic [1:0] STATUS_UNDERFLOW   = 2'd3;

  localparam logic [1:0] SIZE_1B = 2'd0;
  localparam logic [1:0] SIZE_2B = 2'd1;
  localparam logic [1:0] SIZE_4B = 2'd2;

  localparam logic [7:0]  KIND_LIMIT   = 8'h02;
  localparam logic [7:0]  KIND_LE_MASK = 8'h01;
  localparam logic [7:0]  PAD_MASK     = 8'h03;
  localparam int          HDR_BYTES    = 4;
  localparam logic [31:0] STR_LEN_MAX  = 32'h00FF_FFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_OPEN_A,
    ST_OPEN_B,
    ST_OPEN_C,
    ST_SPAN,
    ST_ALIGN,
    ST_CHECK,
    ST_FETCH,
    ST_FETCH_WAIT,
    ST_FINISH,
    ST_STRING,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    RD_HDR_KIND,
    RD_HDR_PAD,
    RD_FETCH
  } rd_sel_t;

  typedef struct packed {
    logic    in_ready;
    logic    capture;
    logic    mem_write;
    rd_sel_t rd_sel;
    logic    kind_latch;
    logic    open_apply;
    logic    align;
    logic    fetch_start;
    logic    fetch_issue;
    logic    fetch_finish;
    logic    span_apply;
    logic    str_apply;
    logic    underflow;
    logic    out_load;
  } cdr_cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic [2:0] in_func;
    logic [2:0] func;
    logic       room_ok;
    logic       last_issue;
    logic       out_free;
  } cdr_sts_t;

endpackage

@@ hw/rtl/cdr_in_if.sv @@
// ----------------------------------------------------------------------------
// CDR request channel
// Carries one command with its operands from the source to the reader.
// ----------------------------------------------------------------------------
interface cdr_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [11:0] byte_index;
  logic [7:0]  byte_value;
  logic [12:0] payload_size;
  logic [1:0]  scalar_size_code;
  logic        sign_extend;
  logic [12:0] span_length;

  modport source (
    output valid, func, byte_index, byte_value, payload_size,
           scalar_size_code, sign_extend, span_length,
    input  ready
  );

  modport sink (
    input  valid, func, byte_index, byte_value, payload_size,
           scalar_size_code, sign_extend, span_length,
    output ready
  );
endinterface

@@ hw/rtl/cdr_out_if.sv @@
// ----------------------------------------------------------------------------
// CDR result channel
// Carries one result per command from the reader to the sink.
// ----------------------------------------------------------------------------
interface cdr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] value;
  logic [11:0] span_offset;
  logic [12:0] span_bytes;
  logic        payload_le;

  modport source (
    output valid, status, value, span_offset, span_bytes, payload_le,
    input  ready
  );

  modport sink (
    input  valid, status, value, span_offset, span_bytes, payload_le,
    output ready
  );
endinterface

@@ hw/rtl/cdr_field_reader_top.sv @@
// ----------------------------------------------------------------------------
// CDR field reader
// Reads encapsulated CDR fields from a byte store filled over the request
// channel.
// ----------------------------------------------------------------------------
// One command is in progress at a time and each gives one result transfer.
// An open reads two header bytes through the single store port, and a scalar
// read that underflows skips the byte fetch. Scalars and string lengths are
// gathered one byte per cycle through the one byte-wide read port of the
// store. A new request is taken while the previous result waits in the
// output register. The store is not cleared after reset; reading bytes never
// written gives undefined values.
module cdr_field_reader_top #(
  parameter int PAYLOAD_BYTES = 4096
) (
  input  logic      clk,
  input  logic      rst,
  cdr_in_if.sink    in_ch,
  cdr_out_if.source out_ch
);

  cdr_pkg::cdr_cmd_t cmd;
  cdr_pkg::cdr_sts_t sts;

  cdr_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  cdr_dpath #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule

@@ hw/rtl/cdr_ctrl.sv @@
// ----------------------------------------------------------------------------
// CDR reader controller
// Sequences each command through the datapath: header reads for an open,
// alignment, room check and byte-serial fetch for scalars and strings.
// ----------------------------------------------------------------------------
module cdr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  cdr_pkg::cdr_sts_t sts,
  output cdr_pkg::cdr_cmd_t cmd
);

  cdr_pkg::state_t state;
  cdr_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cdr_pkg::ST_IDLE: begin
        if (sts.in_valid) begin
          unique case (sts.in_func) inside
            cdr_pkg::FUNC_WRITE:  state_next = cdr_pkg::ST_WRITE;
            cdr_pkg::FUNC_OPEN:   state_next = cdr_pkg::ST_OPEN_A;
            cdr_pkg::FUNC_SPAN:   state_next = cdr_pkg::ST_SPAN;
            cdr_pkg::FUNC_SCALAR, cdr_pkg::FUNC_STRING: state_next = cdr_pkg::ST_ALIGN;
            default:              state_next = cdr_pkg::ST_DONE;
          endcase
        end
      end
      cdr_pkg::ST_WRITE:      state_next = cdr_pkg::ST_DONE;
      cdr_pkg::ST_OPEN_A:     state_next = cdr_pkg::ST_OPEN_B;
      cdr_pkg::ST_OPEN_B:     state_next = cdr_pkg::ST_OPEN_C;
      cdr_pkg::ST_OPEN_C:     state_next = cdr_pkg::ST_DONE;
      cdr_pkg::ST_SPAN:       state_next = cdr_pkg::ST_DONE;
      cdr_pkg::ST_ALIGN:      state_next = cdr_pkg::ST_CHECK;
      cdr_pkg::ST_CHECK: begin
        state_next = sts.room_ok ? cdr_pkg::ST_FETCH : cdr_pkg::ST_DONE;
      end
      cdr_pkg::ST_FETCH: begin
        if (sts.last_issue) begin
          state_next = cdr_pkg::ST_FETCH_WAIT;
        end
      end
      cdr_pkg::ST_FETCH_WAIT: state_next = cdr_pkg::ST_FINISH;
      cdr_pkg::ST_FINISH: begin
        state_next = (sts.func == cdr_pkg::FUNC_STRING) ? cdr_pkg::ST_STRING
                                                        : cdr_pkg::ST_DONE;
      end
      cdr_pkg::ST_STRING:     state_next = cdr_pkg::ST_DONE;
      cdr_pkg::ST_DONE: begin
        if (sts.out_free) begin
          state_next = cdr_pkg::ST_IDLE;
        end
      end
      default:                state_next = cdr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = cdr_pkg::RD_FETCH;
    unique case (state)
      cdr_pkg::ST_IDLE: begin
        cmd.in_ready = !rst;
        cmd.capture  = sts.in_valid && !rst;
      end
      cdr_pkg::ST_WRITE:  cmd.mem_write = 1'b1;
      cdr_pkg::ST_OPEN_A: cmd.rd_sel = cdr_pkg::RD_HDR_KIND;
      cdr_pkg::ST_OPEN_B: begin
        cmd.kind_latch = 1'b1;
        cmd.rd_sel     = cdr_pkg::RD_HDR_PAD;
      end
      cdr_pkg::ST_OPEN_C: cmd.open_apply = 1'b1;
      cdr_pkg::ST_SPAN:   cmd.span_apply = 1'b1;
      cdr_pkg::ST_ALIGN:  cmd.align = 1'b1;
      cdr_pkg::ST_CHECK: begin
        cmd.fetch_start = 1'b1;
        cmd.underflow   = !sts.room_ok;
      end
      cdr_pkg::ST_FETCH:      cmd.fetch_issue = 1'b1;
      cdr_pkg::ST_FETCH_WAIT: cmd.fetch_issue = 1'b0;
      cdr_pkg::ST_FINISH:     cmd.fetch_finish = 1'b1;
      cdr_pkg::ST_STRING:     cmd.str_apply = 1'b1;
      cdr_pkg::ST_DONE:       cmd.out_load = sts.out_free;
      default:                cmd.in_ready = 1'b0;
    endcase
  end

`ifndef ASSERT_OFF
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state != cdr_pkg::ST_IDLE)
    else $error("Accepted transfer did not start a command.");

  a_wait_follows_fetch: assert property (@(posedge clk) disable iff (rst)
    state == cdr_pkg::ST_FETCH_WAIT |-> $past(state) == cdr_pkg::ST_FETCH)
    else $error("Fetch drain entered without a fetch.");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free && state == cdr_pkg::ST_DONE)
    else $error("Result loaded while the output register was occupied.");
`endif

endmodule

@@ hw/rtl/cdr_dpath.sv @@
// ----------------------------------------------------------------------------
// CDR reader datapath
// Holds the payload store, the stream state, the byte assembler and the
// result and output registers, and acts on the controller's commands.
// ----------------------------------------------------------------------------
module cdr_dpath #(
  parameter int PAYLOAD_BYTES = 4096
) (
  input  logic              clk,
  input  logic              rst,
  cdr_in_if.sink            in_ch,
  cdr_out_if.source         out_ch,
  input  cdr_pkg::cdr_cmd_t cmd,
  output cdr_pkg::cdr_sts_t sts
);

  localparam int AW = $clog2(PAYLOAD_BYTES);
  localparam int OW = ($clog2(PAYLOAD_BYTES + 9) > 13) ? $clog2(PAYLOAD_BYTES + 9) : 13;

  logic [7:0] mem [PAYLOAD_BYTES];

  logic [2:0]  cap_func;
  logic [11:0] cap_index;
  logic [7:0]  cap_value;
  logic [12:0] cap_psize;
  logic [1:0]  cap_code;
  logic        cap_sext;
  logic [12:0] cap_slen;

  logic [OW-1:0] usable;
  logic [OW-1:0] offset;
  logic          endian;
  logic [1:0]    pad;
  logic [7:0]    kind;
  logic [7:0]    rdata;
  logic [2:0]    cnt;
  logic [2:0]    acc_idx;
  logic          rd_pend;
  logic [63:0]   acc;

  logic [1:0]  res_status;
  logic [63:0] res_value;
  logic [11:0] res_soff;
  logic [12:0] res_sbytes;

  logic        out_valid;
  logic [1:0]  out_status;
  logic [63:0] out_value;
  logic [11:0] out_soff;
  logic [12:0] out_sbytes;
  logic        out_le;

  logic [AW+11:0] idx_wide;
  logic [AW-1:0]  waddr;
  logic [AW-1:0]  raddr;
  logic           idx_ok;
  logic [OW-1:0]  fetch_pos;
  logic [3:0]     n_bytes;
  logic [2:0]     n_mask;
  logic [2:0]     misalign;
  logic [2:0]     pad_add;
  logic [OW-1:0]  end_pos;
  logic [31:0]    end32;
  logic [31:0]    off32;
  logic [31:0]    len;
  logic           room_n;
  logic           room_span;
  logic           room_str;
  logic [OW-1:0]  psize_sat;
  logic           hdr_short;
  logic           pad_fits;
  logic [63:0]    val_ext;
  logic           out_free;

  function automatic logic has_room(input logic [31:0] end_p, input logic [31:0] off,
                                    input logic [31:0] req);
    has_room = (end_p >= off) && ((end_p - off) >= req);
  endfunction

  assign idx_wide  = (AW + 12)'(cap_index);
  assign waddr     = idx_wide[AW-1:0];
  assign idx_ok    = 32'(cap_index) < 32'(PAYLOAD_BYTES);
  assign fetch_pos = offset + OW'(cnt);

  always_comb begin
    unique case (cmd.rd_sel)
      cdr_pkg::RD_HDR_KIND: raddr = AW'(1);
      cdr_pkg::RD_HDR_PAD:  raddr = AW'(3);
      cdr_pkg::RD_FETCH:    raddr = fetch_pos[AW-1:0];
      default:              raddr = fetch_pos[AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_write && idx_ok) begin
      mem[waddr] <= cap_value;
    end
    rdata <= mem[raddr];
  end

  assign n_bytes  = (cap_func == cdr_pkg::FUNC_STRING) ? 4'd4 : (4'd1 << cap_code);
  assign n_mask   = 3'(n_bytes - 4'd1);
  assign misalign = 3'(offset - OW'(cdr_pkg::HDR_BYTES)) & n_mask;
  assign pad_add  = (3'(n_bytes) - misalign) & n_mask;

  assign end_pos   = usable - OW'(pad);
  assign end32     = 32'(end_pos);
  assign off32     = 32'(offset);
  assign len       = acc[31:0];
  assign room_n    = has_room(end32, off32, 32'(n_bytes));
  assign room_span = has_room(end32, off32, 32'(cap_slen));
  assign room_str  = has_room(end32, off32, len);

  assign psize_sat = (32'(cap_psize) > 32'(PAYLOAD_BYTES)) ? OW'(PAYLOAD_BYTES)
                                                           : OW'(cap_psize);
  assign hdr_short = 32'(cap_psize) < 32'(cdr_pkg::HDR_BYTES);
  assign pad_fits  = 32'(rdata & cdr_pkg::PAD_MASK)
                     <= 32'(psize_sat) - 32'(cdr_pkg::HDR_BYTES);

  always_comb begin
    val_ext = acc;
    if (cap_sext) begin
      case (cap_code)
        cdr_pkg::SIZE_1B: if (acc[7])  val_ext[63:8]  = '1;
        cdr_pkg::SIZE_2B: if (acc[15]) val_ext[63:16] = '1;
        cdr_pkg::SIZE_4B: if (acc[31]) val_ext[63:32] = '1;
        default:          val_ext = acc;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_func  <= in_ch.func;
      cap_index <= in_ch.byte_index;
      cap_value <= in_ch.byte_value;
      cap_psize <= in_ch.payload_size;
      cap_code  <= in_ch.scalar_size_code;
      cap_sext  <= in_ch.sign_extend;
      cap_slen  <= in_ch.span_length;
    end
    if (cmd.kind_latch) begin
      kind <= rdata;
    end
    if (cmd.fetch_start) begin
      cnt     <= '0;
      acc_idx <= '0;
      acc     <= '0;
    end else begin
      if (cmd.fetch_issue) begin
        cnt <= cnt + 3'd1;
      end
      if (rd_pend) begin
        acc_idx <= acc_idx + 3'd1;
        if (endian) begin
          acc[{acc_idx, 3'b000} +: 8] <= rdata;
        end else begin
          acc <= {acc[55:0], rdata};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_status <= cdr_pkg::STATUS_OK;
      res_value  <= '0;
      res_soff   <= '0;
      res_sbytes <= '0;
    end else if (cmd.underflow) begin
      res_status <= cdr_pkg::STATUS_UNDERFLOW;
    end else if (cmd.open_apply) begin
      if (hdr_short) begin
        res_status <= cdr_pkg::STATUS_SHORT;
      end else if (kind >= cdr_pkg::KIND_LIMIT) begin
        res_status <= cdr_pkg::STATUS_UNSUPPORTED;
      end
    end else if (cmd.span_apply) begin
      if (room_span) begin
        res_soff   <= offset[11:0];
        res_sbytes <= cap_slen;
      end else begin
        res_status <= cdr_pkg::STATUS_UNDERFLOW;
      end
    end else if (cmd.fetch_finish) begin
      if (cap_func == cdr_pkg::FUNC_SCALAR) begin
        res_value <= val_ext;
      end
    end else if (cmd.str_apply) begin
      if (len == 32'd0) begin
        res_soff <= offset[11:0];
      end else if (len > cdr_pkg::STR_LEN_MAX || !room_str) begin
        res_status <= cdr_pkg::STATUS_UNDERFLOW;
      end else begin
        res_soff   <= offset[11:0];
        res_sbytes <= 13'(len - 32'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      usable  <= '0;
      offset  <= OW'(cdr_pkg::HDR_BYTES);
      endian  <= 1'b0;
      pad     <= '0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.fetch_issue;
      if (cmd.open_apply) begin
        offset <= OW'(cdr_pkg::HDR_BYTES);
        if (hdr_short || kind >= cdr_pkg::KIND_LIMIT) begin
          usable <= '0;
          pad    <= '0;
          endian <= 1'b0;
        end else begin
          usable <= psize_sat;
          pad    <= pad_fits ? rdata[1:0] : 2'd0;
          endian <= |(kind & cdr_pkg::KIND_LE_MASK);
        end
      end else if (cmd.align) begin
        if (off32 >= 32'(cdr_pkg::HDR_BYTES)) begin
          offset <= offset + OW'(pad_add);
        end
      end else if (cmd.fetch_finish) begin
        offset <= offset + OW'(n_bytes);
      end else if (cmd.span_apply) begin
        if (room_span) begin
          offset <= offset + OW'(cap_slen);
        end
      end else if (cmd.str_apply) begin
        if (len != 32'd0 && len <= cdr_pkg::STR_LEN_MAX && room_str) begin
          offset <= offset + OW'(len);
        end
      end
    end
  end

  assign out_free = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= res_status;
      out_value  <= res_value;
      out_soff   <= res_soff;
      out_sbytes <= res_sbytes;
      out_le     <= endian;
    end
  end

  assign in_ch.ready        = cmd.in_ready;
  assign out_ch.valid       = out_valid;
  assign out_ch.status      = out_status;
  assign out_ch.value       = out_value;
  assign out_ch.span_offset = out_soff;
  assign out_ch.span_bytes  = out_sbytes;
  assign out_ch.payload_le  = out_le;

  assign sts.in_valid   = in_ch.valid;
  assign sts.in_func    = in_ch.func;
  assign sts.func       = cap_func;
  assign sts.room_ok    = room_n;
  assign sts.last_issue = cnt == n_mask;
  assign sts.out_free   = out_free;

`ifndef ASSERT_OFF
  a_pad_within_size: assert property (@(posedge clk) disable iff (rst)
    OW'(pad) <= usable)
    else $error("Pad count exceeds the usable size.");

  a_size_bounded: assert property (@(posedge clk) disable iff (rst)
    32'(usable) <= 32'(PAYLOAD_BYTES))
    else $error("Usable size exceeds the store depth.");

  a_fetch_in_room: assert property (@(posedge clk) disable iff (rst)
    cmd.fetch_issue |-> room_n && fetch_pos < end_pos)
    else $error("Byte fetch issued beyond the end of the payload.");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CDR field reader testbench
// Fills the byte store and drives open, scalar, span and string commands
// through the request channel. A behavioural copy of the reader predicts each
// result when its request transfer completes. The result channel is checked
// field by field against those predictions. Both channels idle at random, and
// the result side is held off for one long stretch.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int STORE_BYTES = 4096;
  localparam int SHADOW = 0;
  localparam int CHECK = 1;
  localparam logic [1:0] SIZE_8B = 2'd3;
  localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
  localparam int HDR_KIND_POS = 1;
  localparam int HDR_PAD_POS = 3;
  localparam int STR_LEN_BYTES = 4;
  localparam int ITEM_TARGET = 1950;
  localparam int HOLD_START = 2000;
  localparam int HOLD_END = 2400;
  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic        drain;
    logic [2:0]  func;
    logic [11:0] byte_index;
    logic [7:0]  byte_value;
    logic [12:0] payload_size;
    logic [1:0]  size_code;
    logic        sign_extend;
    logic [12:0] span_length;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] value;
    logic [11:0] span_offset;
    logic [12:0] span_bytes;
    logic        payload_le;
  } result_t;

  logic clk;
  logic rst;

  cdr_in_if  req_ch ();
  cdr_out_if rsp_ch ();

  cdr_field_reader_top #(
    .PAYLOAD_BYTES(STORE_BYTES)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (req_ch),
    .out_ch(rsp_ch)
  );

  // Two copies of the reader state: one runs ahead while the requests are
  // built, the other follows the request transfers.
  logic [7:0]  byte_copy [2][STORE_BYTES];
  int unsigned used_size [2];
  int unsigned rd_pos [2];
  int unsigned pad_len [2];
  logic        le_flag [2];
  bit          written [STORE_BYTES];

  req_t    request_queue[$];
  result_t due_results[$];
  req_t    driven_req;
  req_t    next_req;
  result_t want;
  bit      drain_next;
  int      errors;
  int      req_gap;
  int      rdy_gap;
  bit      req_burst;
  bit      rdy_burst;
  int      hold_cyc;
  int      quiet_cyc;
  logic    hold_off;

  function automatic int unsigned data_end(input int c);
    return (used_size[c] >= pad_len[c]) ? used_size[c] - pad_len[c] : 0;
  endfunction

  function automatic bit room_at(input int c, input int unsigned p, input int unsigned n);
    int unsigned e;
    e = data_end(c);
    return !(e < p || e - p < n);
  endfunction

  function automatic int unsigned data_left(input int c);
    return (data_end(c) >= rd_pos[c]) ? data_end(c) - rd_pos[c] : 0;
  endfunction

  function automatic int unsigned aligned_pos(input int c, input int unsigned n);
    int unsigned p;
    int unsigned rem;
    p = rd_pos[c];
    if (n > 1 && p >= cdr_pkg::HDR_BYTES) begin
      rem = (p - cdr_pkg::HDR_BYTES) % n;
      if (rem != 0) p += n - rem;
    end
    return p;
  endfunction

  function automatic bit fetch_scalar(input int c, input int unsigned n, input bit sext,
                                      output logic [63:0] v);
    int unsigned i;
    logic [7:0] b;
    v = '0;
    rd_pos[c] = aligned_pos(c, n);
    if (!room_at(c, rd_pos[c], n)) return 1'b0;
    for (i = 0; i < n; i++) begin
      b = byte_copy[c][rd_pos[c] + i];
      if (le_flag[c]) v |= {56'd0, b} << (8 * i);
      else v = (v << 8) | {56'd0, b};
    end
    if (sext && n < 8 && v[8 * n - 1]) v |= ~64'd0 << (8 * n);
    rd_pos[c] += n;
    return 1'b1;
  endfunction

  function automatic result_t reader_step(input int c, input req_t r);
    result_t res;
    int unsigned lim;
    int unsigned pad;
    logic [7:0] kind;
    logic [63:0] word;
    res = '0;
    case (r.func)
      cdr_pkg::FUNC_WRITE: begin
        byte_copy[c][r.byte_index] = r.byte_value;
      end
      cdr_pkg::FUNC_OPEN: begin
        lim = (r.payload_size > STORE_BYTES) ? STORE_BYTES : r.payload_size;
        rd_pos[c] = cdr_pkg::HDR_BYTES;
        kind = byte_copy[c][HDR_KIND_POS];
        if (lim < cdr_pkg::HDR_BYTES || kind >= cdr_pkg::KIND_LIMIT) begin
          res.status = (lim < cdr_pkg::HDR_BYTES) ? cdr_pkg::STATUS_SHORT
                                                  : cdr_pkg::STATUS_UNSUPPORTED;
          used_size[c] = 0;
          pad_len[c] = 0;
          le_flag[c] = 1'b0;
        end else begin
          le_flag[c] = |(kind & cdr_pkg::KIND_LE_MASK);
          pad = byte_copy[c][HDR_PAD_POS] & cdr_pkg::PAD_MASK;
          pad_len[c] = (pad <= lim - cdr_pkg::HDR_BYTES) ? pad : 0;
          used_size[c] = lim;
        end
      end
      cdr_pkg::FUNC_SCALAR: begin
        if (!fetch_scalar(c, 1 << r.size_code, r.sign_extend, res.value)) begin
          res.status = cdr_pkg::STATUS_UNDERFLOW;
          res.value = '0;
        end
      end
      cdr_pkg::FUNC_SPAN: begin
        if (room_at(c, rd_pos[c], r.span_length)) begin
          res.span_offset = 12'(rd_pos[c]);
          res.span_bytes = r.span_length;
          rd_pos[c] += r.span_length;
        end else begin
          res.status = cdr_pkg::STATUS_UNDERFLOW;
        end
      end
      cdr_pkg::FUNC_STRING: begin
        if (!fetch_scalar(c, STR_LEN_BYTES, 1'b0, word)) begin
          res.status = cdr_pkg::STATUS_UNDERFLOW;
        end else if (word == 0) begin
          res.span_offset = 12'(rd_pos[c]);
        end else if (word > cdr_pkg::STR_LEN_MAX || !room_at(c, rd_pos[c], word[31:0])) begin
          res.status = cdr_pkg::STATUS_UNDERFLOW;
        end else begin
          res.span_offset = 12'(rd_pos[c]);
          res.span_bytes = 13'(word - 1);
          rd_pos[c] += word[31:0];
        end
      end
      default: ;
    endcase
    res.payload_le = le_flag[c];
    return res;
  endfunction

  function automatic void reset_copy(input int c);
    int i;
    for (i = 0; i < STORE_BYTES; i++) byte_copy[c][i] = 8'h00;
    used_size[c] = 0;
    rd_pos[c] = cdr_pkg::HDR_BYTES;
    pad_len[c] = 0;
    le_flag[c] = 1'b0;
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int pick_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic req_t base_req();
    req_t q;
    q.drain = 1'b0;
    q.func = cdr_pkg::FUNC_WRITE;
    q.byte_index = 12'($urandom);
    q.byte_value = 8'($urandom);
    q.payload_size = 13'($urandom);
    q.size_code = 2'($urandom);
    q.sign_extend = 1'($urandom);
    q.span_length = 13'($urandom);
    return q;
  endfunction

  task automatic push_raw(input req_t q);
    q.drain = drain_next;
    drain_next = 1'b0;
    request_queue.push_back(q);
    if (q.func == cdr_pkg::FUNC_WRITE) written[q.byte_index] = 1'b1;
    void'(reader_step(SHADOW, q));
  endtask

  task automatic put_byte(input logic [11:0] idx, input logic [7:0] val);
    req_t q;
    q = base_req();
    q.func = cdr_pkg::FUNC_WRITE;
    q.byte_index = idx;
    q.byte_value = val;
    push_raw(q);
  endtask

  // Any store byte the request would read and that holds nothing yet is
  // written first with a random value.
  task automatic queue_item(input req_t q);
    int unsigned first;
    int unsigned cnt;
    int unsigned i;
    first = 0;
    cnt = 0;
    case (q.func)
      cdr_pkg::FUNC_OPEN: begin
        first = HDR_KIND_POS;
        cnt = HDR_PAD_POS - HDR_KIND_POS + 1;
      end
      cdr_pkg::FUNC_SCALAR: begin
        cnt = 1 << q.size_code;
        first = aligned_pos(SHADOW, cnt);
        if (!room_at(SHADOW, first, cnt)) cnt = 0;
      end
      cdr_pkg::FUNC_STRING: begin
        cnt = STR_LEN_BYTES;
        first = aligned_pos(SHADOW, cnt);
        if (!room_at(SHADOW, first, cnt)) cnt = 0;
      end
      default: ;
    endcase
    for (i = first; i < first + cnt; i++) begin
      if (!written[i]) put_byte(12'(i), rand_byte());
    end
    push_raw(q);
  endtask

  task automatic add_open(input logic [12:0] psize);
    req_t q;
    q = base_req();
    q.func = cdr_pkg::FUNC_OPEN;
    q.payload_size = psize;
    queue_item(q);
  endtask

  task automatic add_scalar(input logic [1:0] code, input bit sext, input bit fresh);
    int unsigned n;
    int unsigned p;
    int unsigned i;
    req_t q;
    n = 1 << code;
    p = aligned_pos(SHADOW, n);
    if (fresh && room_at(SHADOW, p, n)) begin
      for (i = 0; i < n; i++) put_byte(12'(p + i), rand_byte());
    end
    q = base_req();
    q.func = cdr_pkg::FUNC_SCALAR;
    q.size_code = code;
    q.sign_extend = sext;
    queue_item(q);
  endtask

  task automatic add_string(input logic [31:0] len_word);
    int unsigned p;
    int unsigned i;
    req_t q;
    p = aligned_pos(SHADOW, STR_LEN_BYTES);
    if (room_at(SHADOW, p, STR_LEN_BYTES)) begin
      for (i = 0; i < STR_LEN_BYTES; i++) begin
        if (le_flag[SHADOW]) put_byte(12'(p + i), len_word[8 * i +: 8]);
        else put_byte(12'(p + i), len_word[8 * (STR_LEN_BYTES - 1 - i) +: 8]);
      end
    end
    q = base_req();
    q.func = cdr_pkg::FUNC_STRING;
    queue_item(q);
  endtask

  task automatic add_span(input logic [12:0] len);
    req_t q;
    q = base_req();
    q.func = cdr_pkg::FUNC_SPAN;
    q.span_length = len;
    queue_item(q);
  endtask

  task automatic add_spare(input logic [2:0] code);
    req_t q;
    q = base_req();
    q.func = code;
    queue_item(q);
  endtask

  task automatic add_message();
    int unsigned body;
    int unsigned op;
    int unsigned left;
    logic [7:0] kind;
    if ($urandom_range(0, 9) == 0) body = $urandom_range(0, STORE_BYTES - cdr_pkg::HDR_BYTES);
    else body = $urandom_range(0, 60);
    if ($urandom_range(0, 19) == 0) kind = 8'($urandom_range(cdr_pkg::KIND_LIMIT, 255));
    else kind = 8'($urandom_range(0, 1));
    put_byte(12'd0, rand_byte());
    put_byte(12'(HDR_KIND_POS), kind);
    put_byte(12'd2, rand_byte());
    put_byte(12'(HDR_PAD_POS), rand_byte());
    if ($urandom_range(0, 9) == 0) add_open(13'($urandom_range(0, 8191)));
    else add_open(13'(body + cdr_pkg::HDR_BYTES));
    repeat ($urandom_range(3, 12)) begin
      op = $urandom_range(0, 19);
      left = data_left(SHADOW);
      if (op < 9) begin
        add_scalar(2'($urandom), 1'($urandom), $urandom_range(0, 9) < 6);
      end else if (op < 13) begin
        case ($urandom_range(0, 9))
          0: add_string($urandom);
          1: add_string((left > STR_LEN_BYTES) ? left - STR_LEN_BYTES : 0);
          default: add_string($urandom_range(0, 24));
        endcase
      end else if (op < 17) begin
        case ($urandom_range(0, 9))
          0: add_span(13'($urandom_range(0, 8191)));
          1: add_span(13'(left));
          default: add_span(13'($urandom_range(0, 16)));
        endcase
      end else begin
        case ($urandom_range(0, 3))
          0: put_byte(12'($urandom), rand_byte());
          1: add_spare(3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI)));
          2: add_open(13'($urandom_range(0, 8191)));
          default: add_scalar(2'($urandom), 1'($urandom), 1'b0);
        endcase
      end
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    bit mid_pause;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.func = cdr_pkg::FUNC_WRITE;
    req_ch.byte_index = '0;
    req_ch.byte_value = '0;
    req_ch.payload_size = '0;
    req_ch.scalar_size_code = cdr_pkg::SIZE_1B;
    req_ch.sign_extend = 1'b0;
    req_ch.span_length = '0;
    rsp_ch.ready = 1'b0;
    errors = 0;
    drain_next = 1'b0;
    mid_pause = 1'b0;
    reset_copy(SHADOW);
    reset_copy(CHECK);

    // Reads before any open all underflow.
    add_scalar(SIZE_8B, 1'b1, 1'b0);
    add_string(32'd0);
    add_span(13'd0);
    add_spare(FUNC_SPARE_LO);
    add_spare(FUNC_SPARE_HI);
    put_byte(12'(HDR_KIND_POS), 8'hFF);
    add_open(13'd4096);
    add_open(13'd3);
    put_byte(12'(HDR_KIND_POS), 8'h00);
    put_byte(12'(HDR_PAD_POS), 8'h03);
    // The pad count does not fit in a one-byte body and is dropped.
    add_open(13'd5);
    add_scalar(cdr_pkg::SIZE_1B, 1'b1, 1'b1);
    add_scalar(cdr_pkg::SIZE_1B, 1'b0, 1'b0);
    add_open(13'd8191);
    add_span(13'd4089);
    add_span(13'd1);
    put_byte(12'(HDR_PAD_POS), 8'h00);
    add_open(13'd8191);
    add_span(13'd4092);
    add_span(13'd0);
    put_byte(12'(HDR_KIND_POS), cdr_pkg::KIND_LE_MASK);
    add_open(13'd64);
    add_scalar(cdr_pkg::SIZE_2B, 1'b1, 1'b1);
    add_scalar(cdr_pkg::SIZE_4B, 1'b1, 1'b1);
    add_scalar(SIZE_8B, 1'b1, 1'b1);
    add_string(32'd0);
    add_string(32'd6);
    add_string(32'hFFFF_FFFF);
    put_byte(12'(HDR_KIND_POS), 8'h00);
    add_open(13'd64);
    add_scalar(SIZE_8B, 1'b1, 1'b1);
    add_scalar(cdr_pkg::SIZE_2B, 1'b0, 1'b1);

    drain_next = 1'b1;
    while (request_queue.size() < ITEM_TARGET) begin
      if (!mid_pause && request_queue.size() >= ITEM_TARGET / 2) begin
        drain_next = 1'b1;
        mid_pause = 1'b1;
      end
      add_message();
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (request_queue.size() != 0 || req_ch.valid || due_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (due_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, due_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_gap <= 0;
      req_burst <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) due_results.push_back(reader_step(CHECK, driven_req));
      if (!req_ch.valid || req_ch.ready) begin
        if (req_gap != 0) begin
          req_gap <= req_gap - 1;
          req_ch.valid <= 1'b0;
        end else if (request_queue.size() != 0 &&
                     !(request_queue[0].drain && due_results.size() != 0)) begin
          next_req = request_queue.pop_front();
          driven_req <= next_req;
          req_ch.valid <= 1'b1;
          req_ch.func <= next_req.func;
          req_ch.byte_index <= next_req.byte_index;
          req_ch.byte_value <= next_req.byte_value;
          req_ch.payload_size <= next_req.payload_size;
          req_ch.scalar_size_code <= next_req.size_code;
          req_ch.sign_extend <= next_req.sign_extend;
          req_ch.span_length <= next_req.span_length;
          if ($urandom_range(0, 149) == 0) req_burst <= !req_burst;
          if (!req_burst && $urandom_range(0, 1) == 0) req_gap <= pick_stall();
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off on the result side, counted from the end of reset.
  always @(posedge clk) begin
    if (rst) begin
      hold_cyc <= 0;
    end else if (hold_cyc != HOLD_END) begin
      hold_cyc <= hold_cyc + 1;
    end
  end

  assign hold_off = (hold_cyc >= HOLD_START) && (hold_cyc < HOLD_END);

  // Result monitor and ready generation.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rdy_gap <= 0;
      rdy_burst <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: result transfer with none expected, got status %h value %h",
                   $time, rsp_ch.status, rsp_ch.value);
          errors++;
        end else begin
          want = due_results.pop_front();
          check_field("status", want.status, rsp_ch.status);
          check_field("value", want.value, rsp_ch.value);
          check_field("span_offset", want.span_offset, rsp_ch.span_offset);
          check_field("span_bytes", want.span_bytes, rsp_ch.span_bytes);
          check_field("payload_le", want.payload_le, rsp_ch.payload_le);
        end
      end
      if ($urandom_range(0, 199) == 0) rdy_burst <= !rdy_burst;
      if (hold_off) begin
        rsp_ch.ready <= 1'b0;
      end else if (rdy_gap != 0) begin
        rdy_gap <= rdy_gap - 1;
        rsp_ch.ready <= 1'b0;
      end else if (!rdy_burst && $urandom_range(0, 3) == 0) begin
        rdy_gap <= pick_stall() - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cyc <= 0;
    end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cyc <= 0;
    end else if (quiet_cyc >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cyc);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cyc <= quiet_cyc + 1;
    end
  end

endmodule
